@@ design/assert_macros.svh @@
// Assertion macros shared by the erode/dilate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BED_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bed assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define BED_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bed assertion failed");

`endif

@@ design/bed_pkg.sv @@
// Types and constants for the 3x3 binary erode/dilate block.
package bed_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_ROWS   = 3;
    localparam int WIN_CELLS  = 2;
    localparam int CENTER_ROW = 1;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = 2;
    localparam int RES_CNT_W  = 3;

    localparam logic [PIX_W-1:0]  PIX_FG     = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_BG     = 8'd0;
    localparam logic [PIX_W-1:0]  THRESH_RST = 8'd128;
    localparam logic [SIZE_W-1:0] SIZE_RST   = 11'd1024;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef enum logic [1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_MODE       = 2'd1,
        CFG_IMG_WIDTH  = 2'd2,
        CFG_IMG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_bed_in;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [PIX_W-1:0] out_pixel;
        logic             last;
    } t_bed_out;

    // running reduction handed along the window cells
    typedef struct packed {
        logic all1;
        logic any1;
    } t_bed_red;

endpackage

@@ design/binary_erode_dilate_3x3.sv @@
// Top level: streaming 3x3 binary erosion / dilation with border pass-through.
//
//  channel   direction  handshake              payload
//  pixel     in         i_valid / o_stall      i_data (t_bed_in)
//  result    out        o_valid / i_stall      o_data (t_bed_out)
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
//  One pixel item a clock while o_stall is low; an accepted item waits in stage 1 until
//  the result queue has room. Pixels on the last row or last column, outside row 0 and
//  column 0, cause two results; the result port gives one per clock while i_stall is low,
//  so input stalls while stage 1 is full and three or more results are queued.
//  Synchronous active-low reset clears counters, window, queue and configuration registers;
//  line stores are not cleared.
module binary_erode_dilate_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  bed_pkg::t_bed_in                  i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output bed_pkg::t_bed_out                 o_data,
    input  logic                              i_cfg_we,
    input  bed_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [bed_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bed_pkg::*;
    `include "assert_macros.svh"

    // counter widths hold the maximum size itself; addresses hold one less
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int XW_W = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int XW_H = (RW > SIZE_W) ? RW : SIZE_W;

    // ---------------- configuration registers ----------------
    logic [PIX_W-1:0]   r_thresh;
    logic               r_mode;
    logic [SIZE_W-1:0]  r_img_w;
    logic [SIZE_W-1:0]  r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_mode   <= MODE_ERODE;
            r_img_w  <= SIZE_RST;
            r_img_h  <= SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:  r_thresh <= i_cfg_data[PIX_W-1:0];
                CFG_MODE:       r_mode   <= i_cfg_data[0];
                CFG_IMG_WIDTH:  r_img_w  <= i_cfg_data[SIZE_W-1:0];
                CFG_IMG_HEIGHT: r_img_h  <= i_cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize clamps to the maximum
    logic [XW_W-1:0] w_w_x;
    logic [XW_H-1:0] w_h_x;
    logic [CW-1:0]   w_w;
    logic [RW-1:0]   w_h;

    assign w_w_x = XW_W'(r_img_w);
    assign w_h_x = XW_H'(r_img_h);
    assign w_w   = (w_w_x == '0) ? CW'(1) :
                   (w_w_x > XW_W'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_w_x);
    assign w_h   = (w_h_x == '0) ? RW'(1) :
                   (w_h_x > XW_H'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(w_h_x);

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic w_room;
    logic w_accept;
    logic w_s1_adv;

    assign w_s1_adv = r_s1_valid && w_room;
    assign o_stall  = r_s1_valid && !w_room;
    assign w_accept = i_valid && !o_stall;

    // ---------------- position of the arriving pixel ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          w_wrap;
    logic [CW-1:0] w_c;
    logic [RW-1:0] w_rr;
    logic [RW-1:0] w_r;
    logic [CW-1:0] w_cn;
    logic [RW-1:0] w_rn;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          w_b;

    always_comb begin
        // a column left beyond a shrunken width wraps into the next row
        w_wrap = (r_col >= w_w);
        if (i_data.frame_start) begin
            w_c  = '0;
            w_rr = '0;
        end else if (w_wrap) begin
            w_c  = '0;
            w_rr = r_row + RW'(1);
        end else begin
            w_c  = r_col;
            w_rr = r_row;
        end
        w_r  = (w_rr >= w_h) ? '0 : w_rr;
        w_cn = w_c + CW'(1);
        w_rn = w_r + RW'(1);
        if (w_cn >= w_w) begin
            n_col = '0;
            n_row = (w_rn >= w_h) ? '0 : w_rn;
        end else begin
            n_col = w_cn;
            n_row = w_r;
        end
    end

    assign w_b = (i_data.pixel >= r_thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1: item waiting for line data ----------------
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_b;
    logic [POS_W-1:0] r_s1_row;
    logic [POS_W-1:0] r_s1_col;
    logic             r_s1_delay;   // emits the lagged result for (r-1, c-1)
    logic             r_s1_ctr;     // lagged result sits on the top or left border
    logic             r_s1_border;  // pixel itself is on the bottom or right border
    logic             r_fwd;
    logic             r_fwd_up;
    logic             r_fwd_up2;
    logic             w_s1_up;
    logic             w_s1_up2;
    logic [1:0]       w_rd_data;
    logic             n_s1_valid;

    // same column written by the item now leaving: take its values, not the store's
    assign w_s1_up  = r_fwd ? r_fwd_up  : w_rd_data[0];
    assign w_s1_up2 = r_fwd ? r_fwd_up2 : w_rd_data[1];

    assign n_s1_valid = w_accept ? 1'b1 : (w_s1_adv ? 1'b0 : r_s1_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr   <= w_c[AW-1:0];
            r_s1_b      <= w_b;
            r_s1_row    <= POS_W'(w_r);
            r_s1_col    <= POS_W'(w_c);
            r_s1_delay  <= (w_r != '0) && (w_c != '0);
            r_s1_ctr    <= (w_r <= RW'(1)) || (w_c <= CW'(1));
            r_s1_border <= (w_r == w_h - RW'(1)) || (w_c == w_w - CW'(1));
            r_fwd       <= w_s1_adv && (r_s1_addr == w_c[AW-1:0]);
            r_fwd_up    <= r_s1_b;
            r_fwd_up2   <= w_s1_up;
        end
    end

    bed_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_c[AW-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({w_s1_up, r_s1_b})
    );

    // ---------------- window: chain of column cells ----------------
    // incoming column: bit 0 two rows up, bit 1 row above, bit 2 current row
    logic [WIN_ROWS-1:0] w_col [0:WIN_CELLS];
    t_bed_red            w_red [0:WIN_CELLS];

    assign w_col[0]      = {r_s1_b, w_s1_up, w_s1_up2};
    assign w_red[0].all1 = &w_col[0];
    assign w_red[0].any1 = |w_col[0];

    for (genvar g = 0; g < WIN_CELLS; g++) begin : g_cell
        bed_win_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_s1_adv),
            .i_col   (w_col[g]),
            .i_red   (w_red[g]),
            .o_col   (w_col[g+1]),
            .o_red   (w_red[g+1])
        );
    end

    // ---------------- results ----------------
    logic       w_center;
    logic       w_res;
    t_bed_out   w_lag;
    t_bed_out   w_edge;
    t_bed_out   w_item0;
    logic [1:0] w_push_n;

    // first cell holds the column that becomes the window centre column
    assign w_center = w_col[1][CENTER_ROW];
    assign w_res    = r_s1_ctr ? w_center :
                      (r_mode == MODE_DILATE) ? w_red[WIN_CELLS].any1
                                              : w_red[WIN_CELLS].all1;

    assign w_lag.out_row   = r_s1_row - POS_W'(1);
    assign w_lag.out_col   = r_s1_col - POS_W'(1);
    assign w_lag.out_pixel = w_res ? PIX_FG : PIX_BG;
    assign w_lag.last      = !r_s1_border;

    assign w_edge.out_row   = r_s1_row;
    assign w_edge.out_col   = r_s1_col;
    assign w_edge.out_pixel = r_s1_b ? PIX_FG : PIX_BG;
    assign w_edge.last      = 1'b1;

    assign w_item0  = r_s1_delay ? w_lag : w_edge;
    assign w_push_n = w_s1_adv ? ({1'b0, r_s1_delay} + {1'b0, r_s1_border}) : 2'd0;

    bed_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_item0  (w_item0),
        .i_item1  (w_edge),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .o_item   (o_data),
        .i_stall  (i_stall)
    );

    // an accepted item always lands in stage 1
    `BED_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_s1_valid)
    // each advance moves the window one column along the cell chain
    `BED_ASSERT_NXT(a_win_shift, i_clk, i_rst_n, w_s1_adv, w_col[WIN_CELLS] == $past(w_col[WIN_CELLS-1]))

endmodule

@@ design/bed_line_store.sv @@
// Two-bit-wide line store: bit 0 row above, bit 1 row two above.
module bed_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [1:0]                 o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [1:0]                 i_wr_data
);
    import bed_pkg::*;

    logic [1:0] r_mem [0:DEPTH-1];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/bed_win_cell.sv @@
// One window column cell: holds three bits and extends the all/any chain.
module bed_win_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [bed_pkg::WIN_ROWS-1:0]   i_col,
    input  bed_pkg::t_bed_red              i_red,
    output logic [bed_pkg::WIN_ROWS-1:0]   o_col,
    output bed_pkg::t_bed_red              o_red
);
    import bed_pkg::*;

    logic [WIN_ROWS-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col      = r_col;
    assign o_red.all1 = i_red.all1 & (&r_col);
    assign o_red.any1 = i_red.any1 | (|r_col);

endmodule

@@ design/bed_res_fifo.sv @@
// Small result queue taking up to two items a cycle, giving one unless i_stall holds it.
module bed_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_push_n,
    input  bed_pkg::t_bed_out    i_item0,
    input  bed_pkg::t_bed_out    i_item1,
    output logic                 o_room,
    output logic                 o_valid,
    output bed_pkg::t_bed_out    o_item,
    input  logic                 i_stall
);
    import bed_pkg::*;
    `include "assert_macros.svh"

    t_bed_out               r_mem [0:RES_DEPTH-1];
    logic [RES_PTR_W-1:0]   r_wr;
    logic [RES_PTR_W-1:0]   r_rd;
    logic [RES_CNT_W-1:0]   r_count;
    logic [RES_PTR_W-1:0]   w_wr1;
    logic                   w_pop;

    assign w_wr1   = r_wr + RES_PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign o_room  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_item0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr1] <= i_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + RES_PTR_W'(i_push_n);
            r_rd    <= r_rd + RES_PTR_W'(w_pop);
            r_count <= r_count + RES_CNT_W'(i_push_n) - RES_CNT_W'(w_pop);
        end
    end

    `BED_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= RES_CNT_W'(RES_DEPTH))
    // a result that is not last always has its partner queued behind it
    `BED_ASSERT_IMP(a_partner_queued, i_clk, i_rst_n, o_valid && !o_item.last, r_count >= 3'd2)

endmodule

@@ bench/tb_binary_erode_dilate_3x3.sv @@
// Self-checking testbench for the streaming 3x3 binary erode/dilate block.
module tb_binary_erode_dilate_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import bed_pkg::*;

    localparam int unsigned     MAX_W         = 1024;
    localparam int unsigned     MAX_H         = 1024;
    localparam int unsigned     RANDOM_ITEMS  = 400;
    // time for an item in stage 1 to reach the result queue, plus margin
    localparam int unsigned     SETTLE_CYCLES = 8;
    localparam longint unsigned CYCLE_LIMIT   = 2_500_000;

    // Predicts the raster of results and holds them until the block delivers them.
    class erode_dilate_scoreboard;
        logic [PIX_W-1:0]  threshold;
        logic              mode;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        bit                line_above [MAX_W];
        bit                line_two_above [MAX_W];
        // column-major: [2:0] oldest column, [8:6] newest; row r-2 at the low bit
        bit [8:0]          window;
        int unsigned       row;
        int unsigned       col;
        t_bed_out          pending [$];
        int unsigned       failures;

        function new();
            threshold  = THRESH_RST;
            mode       = MODE_ERODE;
            width_reg  = SIZE_RST;
            height_reg = SIZE_RST;
            window     = '0;
            row        = 0;
            col        = 0;
            failures   = 0;
        endfunction

        // zero acts as one, anything past the top acts as the top
        function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD:  threshold  = data[PIX_W-1:0];
                CFG_MODE:       mode       = data[0];
                CFG_IMG_WIDTH:  width_reg  = data;
                CFG_IMG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function t_bed_out make_result(int unsigned r, int unsigned c, bit fg);
            t_bed_out rec;
            rec.out_row   = r[POS_W-1:0];
            rec.out_col   = c[POS_W-1:0];
            rec.out_pixel = fg ? PIX_FG : PIX_BG;
            rec.last      = 1'b0;
            return rec;
        endfunction

        function void note_pixel(t_bed_in item);
            int unsigned w, h, r, c, n;
            bit          fg, up, up2, res;
            t_bed_out    found [2];
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_H);
            if (item.frame_start) begin
                row = 0;
                col = 0;
            end
            // sizes may have shrunk under the current position
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (row >= h) row = 0;
            r = row;
            c = col;

            fg  = (item.pixel >= threshold);
            up  = line_above[c];
            up2 = line_two_above[c];
            line_two_above[c] = up;
            line_above[c]     = fg;
            window = {fg, up, up2, window[8:3]};

            n = 0;
            // delayed result for the pixel up and to the left
            if (r >= 1 && c >= 1) begin
                if (r < 2 || c < 2)
                    res = window[4];
                else if (mode == MODE_ERODE)
                    res = &window;
                else
                    res = |window;
                found[n] = make_result(r - 1, c - 1, res);
                n++;
            end
            // last row or last column goes straight out
            if (r == h - 1 || c == w - 1) begin
                found[n] = make_result(r, c, fg);
                n++;
            end
            for (int k = 0; k < n; k++) begin
                if (k == n - 1) found[k].last = 1'b1;
                pending.push_back(found[k]);
            end

            col = c + 1;
            if (col >= w) begin
                col = 0;
                row = r + 1;
                if (row >= h) row = 0;
            end
        endfunction

        function void check_result(t_bed_out got);
            t_bed_out want;
            if (pending.size() == 0) begin
                $error("unexpected result: row %0d col %0d pixel %0d",
                       got.out_row, got.out_col, got.out_pixel);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.out_row !== want.out_row) begin
                $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                failures++;
            end
            if (got.out_col !== want.out_col) begin
                $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                failures++;
            end
            if (got.out_pixel !== want.out_pixel) begin
                $error("out_pixel: expected %0d, got %0d", want.out_pixel, got.out_pixel);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_bed_in               i_data     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_bed_out              o_data;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bit                     idling_on = 1'b0;
    int unsigned            hold_left = 0;
    longint unsigned        cycles    = 0;
    erode_dilate_scoreboard sb        = new();

    binary_erode_dilate_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("binary_erode_dilate_3x3 verification failed");
            $finish;
        end
    end

    // both handshakes are sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_pixel(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    // mostly short idle runs, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (hold_left == 0 && idling_on && $urandom_range(0, 99) < 25)
            hold_left = idle_len();
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // grey level biased towards foreground by fg_pct, with values on and just below the threshold
    function automatic logic [PIX_W-1:0] grey_pixel(int unsigned fg_pct,
                                                    logic [PIX_W-1:0] thr);
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 5)  return thr;
        if (roll < 8)  return thr - 8'd1;
        if (roll < 10) return PIX_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < fg_pct) return PIX_W'($urandom_range(thr, 255));
        return PIX_W'($urandom_range(0, (thr == 0) ? 0 : thr - 1));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit fs);
        int unsigned gap;
        t_bed_in     item;
        gap = (idling_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        item.pixel       = pix;
        item.frame_start = fs;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid, let every expected result drain, then cover result-less items in flight
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [PIX_W-1:0] thr, input logic m,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        settle();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_MODE, CFG_DATA_W'(m));
        write_reg(CFG_IMG_WIDTH, w);
        write_reg(CFG_IMG_HEIGHT, h);
    endtask

    // open_frame marks the first item; noise_pct scatters stray frame starts
    task automatic send_stream(input int unsigned count, input int unsigned fg_pct,
                               input bit open_frame, input int unsigned noise_pct);
        bit fs;
        for (int unsigned k = 0; k < count; k++) begin
            fs = (open_frame && k == 0) || ($urandom_range(0, 99) < noise_pct);
            send_pixel(grey_pixel(fg_pct, sb.threshold), fs);
        end
    endtask

    task automatic send_frame(input logic [PIX_W-1:0] seq [9], input bit open_frame);
        foreach (seq[k]) send_pixel(seq[k], open_frame && k == 0);
    endtask

    initial begin : stimulus
        int unsigned       done, roll, ew, eh, n, fg_pct;
        logic [SIZE_W-1:0] w_reg, h_reg;
        logic [PIX_W-1:0]  thr;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idling_on = 1'b1;
        // reset sizes and threshold: row 0 of a 1024-wide frame gives nothing yet
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);

        // 3x3 frames with the reset threshold, erosion
        settle();
        write_reg(CFG_IMG_WIDTH, 11'd3);
        write_reg(CFG_IMG_HEIGHT, 11'd3);
        // all at or above 128: the centre survives
        send_frame('{255, 128, 200, 129, 255, 128, 250, 131, 128}, 1'b1);
        // counters wrap into a second frame; one background corner kills the centre
        send_frame('{255, 255, 255, 255, 255, 255, 255, 255, 127}, 1'b0);

        // dilation, only 255 counts: a lone corner pixel grows into the centre
        settle();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_DILATE));
        write_reg(CFG_THRESHOLD, 11'd255);
        send_frame('{255, 0, 0, 0, 254, 0, 0, 0, 0}, 1'b1);

        // zero sizes act as a 1x1 frame; threshold 0 makes everything foreground
        configure(8'd0, MODE_ERODE, 11'd0, 11'd0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);

        // width shrinks with the position beyond it: column wraps, row advances
        configure(8'd128, MODE_ERODE, 11'd8, 11'd6);
        idling_on = 1'b0;
        send_stream(30, 90, 1'b1, 0);
        settle();
        write_reg(CFG_IMG_WIDTH, 11'd4);
        send_stream(14, 90, 1'b0, 0);

        // oversize width on a single row, then a single tall column
        idling_on = 1'b1;
        configure(8'd100, MODE_DILATE, 11'd2047, 11'd1);
        send_stream(150, 20, 1'b1, 0);
        configure(8'd200, MODE_ERODE, 11'd1, 11'd1024);
        send_stream(150, 50, 1'b1, 0);

        // random frames, mostly small and well formed, a few stray frame starts
        done = 0;
        while (done < RANDOM_ITEMS) begin
            roll  = $urandom_range(0, 99);
            w_reg = (roll < 5) ? 11'd0 :
                    (roll < 9) ? SIZE_W'($urandom_range(1025, 2047)) :
                                 SIZE_W'($urandom_range(1, 12));
            roll  = $urandom_range(0, 99);
            h_reg = (roll < 5) ? 11'd0 :
                    (roll < 9) ? SIZE_W'($urandom_range(1025, 2047)) :
                                 SIZE_W'($urandom_range(1, 8));
            roll  = $urandom_range(0, 99);
            thr   = (roll < 10) ? 8'd0 : (roll < 20) ? 8'd255 : PIX_W'($urandom_range(0, 255));
            configure(thr, 1'($urandom_range(0, 1)), w_reg, h_reg);

            case ($urandom_range(0, 3))
                0:       fg_pct = 5;
                1:       fg_pct = 50;
                2:       fg_pct = 90;
                default: fg_pct = 97;
            endcase
            idling_on = ($urandom_range(0, 3) != 0);
            ew = sb.clamp_size(w_reg, MAX_W);
            eh = sb.clamp_size(h_reg, MAX_H);
            if (ew > 12 || eh > 8)
                n = $urandom_range(10, 40);
            else
                n = ew * eh * $urandom_range(1, 3) + $urandom_range(0, ew);
            send_stream(n, fg_pct, 1'b1, 2);
            done += n;
        end

        settle();
        if (sb.failures == 0)
            $display("binary_erode_dilate_3x3 verification clean");
        else
            $display("binary_erode_dilate_3x3 verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/bed_pkg.sv
design/bed_line_store.sv
design/bed_win_cell.sv
design/bed_res_fifo.sv
design/binary_erode_dilate_3x3.sv
bench/tb_binary_erode_dilate_3x3.sv
